@@ design/assert_macros.svh @@
// Assertion macros shared by the percent decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every edge.
`define ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

@@ design/pdsel_pkg.sv @@
// Shared types, character codes and helper functions of the percent decoder.
`default_nettype none
package pdsel_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One decoded run: up to three bytes caused by one input beat.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      cnt;
        logic            last;
    } pdsel_job_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } pdsel_hex_t;

    function automatic pdsel_hex_t hex_val(input logic [7:0] c);
        pdsel_hex_t r;
        r.ok  = 1'b1;
        r.val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r.val = c[3:0] + 4'd9;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_safe(input logic [7:0] v);
        return (v >= 8'h30 && v <= 8'h39) || (v >= 8'h41 && v <= 8'h5A) ||
               (v >= 8'h61 && v <= 8'h7A) || (v >= 8'h26 && v <= 8'h2F) ||
               v == 8'h21 || v == 8'h24 || v == 8'h3A || v == 8'h3B ||
               v == 8'h3D || v == 8'h3F || v == 8'h40 || v == 8'h5F;
    endfunction

endpackage
`default_nettype wire

@@ design/percent_decoder_selective.sv @@
// Top level of the streaming selective URL percent decoder.
// Usage:
//   Input channel s_*: one encoded byte per beat (s_byte), s_last marks the
//   final byte of a message. Output channel m_*: one decoded byte per beat;
//   m_run_end flags the last byte caused by an input beat, m_msg_end the last
//   byte of the message. '+' decodes to space, %XX to its byte unless that
//   byte is in the safe set, in which case the escape passes through as-is.
//   An accepted beat's run is written into the job queue and shown on m_*
//   from its head. Throughput: one input beat per cycle while each beat
//   yields at most one byte and m_ready stays high; a beat that yields two
//   or three bytes holds the output port until all are taken; the job queue
//   (QUEUE_DEPTH runs) absorbs the difference before s_ready drops. Beats
//   that only open an escape yield nothing. A stall on m_ready backs up into
//   the queue, then drops s_ready; no byte is lost or repeated. Synchronous
//   active-low reset empties the queue and clears any pending escape.
`default_nettype none
module percent_decoder_selective #(
    parameter int QUEUE_DEPTH = pdsel_pkg::QUEUE_DEPTH_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [7:0] s_byte,
    input  wire        s_last,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_byte,
    output logic       m_run_end,
    output logic       m_msg_end
);
    import pdsel_pkg::*;

    pdsel_job_t push_job;
    pdsel_job_t head;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    pdsel_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_byte   (s_byte),
        .s_last   (s_last),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    pdsel_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    pdsel_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_byte    (m_byte),
        .m_run_end (m_run_end),
        .m_msg_end (m_msg_end)
    );

endmodule
`default_nettype wire

@@ design/pdsel_front.sv @@
// Front end: tracks escape state and turns each input beat into a decoded run.
`default_nettype none
`include "assert_macros.svh"
module pdsel_front (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire  [7:0]              s_byte,
    input  wire                     s_last,
    input  wire                     q_full,
    output logic                    push,
    output pdsel_pkg::pdsel_job_t   push_job
);
    import pdsel_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_DIG  = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] digit_reg, digit_next;

    pdsel_hex_t hx, h1;
    logic [7:0] pl_byte;
    logic       pl_pct;
    logic       s_fire;
    logic [7:0] dec;

    assign s_ready = !q_full;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        hx      = hex_val(s_byte);
        h1      = hex_val(digit_reg);
        dec     = {h1.val, hx.val};
        // plain decode of the current byte; a lone '%' opens an escape
        pl_pct  = (s_byte == CH_PCT) && !s_last;
        pl_byte = (s_byte == CH_PLUS) ? CH_SPACE : s_byte;

        phase_next    = PH_IDLE;
        digit_next    = digit_reg;
        push_job.data = '0;
        push_job.cnt  = 2'd0;
        push_job.last = s_last;

        unique case (phase_reg)
            PH_PCT: begin
                if (hx.ok) begin
                    if (s_last) begin
                        push_job.data[0] = CH_PCT;
                        push_job.data[1] = s_byte;
                        push_job.cnt     = 2'd2;
                    end else begin
                        digit_next = s_byte;
                        phase_next = PH_DIG;
                    end
                end else begin
                    push_job.data[0] = CH_PCT;
                    push_job.data[1] = pl_byte;
                    push_job.cnt     = pl_pct ? 2'd1 : 2'd2;
                    if (pl_pct) phase_next = PH_PCT;
                end
            end
            PH_DIG: begin
                if (hx.ok && h1.ok) begin
                    if (is_safe(dec)) begin
                        push_job.data[0] = CH_PCT;
                        push_job.data[1] = digit_reg;
                        push_job.data[2] = s_byte;
                        push_job.cnt     = 2'd3;
                    end else begin
                        push_job.data[0] = dec;
                        push_job.cnt     = 2'd1;
                    end
                end else begin
                    push_job.data[0] = CH_PCT;
                    push_job.data[1] = digit_reg;
                    push_job.data[2] = pl_byte;
                    push_job.cnt     = pl_pct ? 2'd2 : 2'd3;
                    if (pl_pct) phase_next = PH_PCT;
                end
            end
            default: begin
                push_job.data[0] = pl_byte;
                push_job.cnt     = pl_pct ? 2'd0 : 2'd1;
                if (pl_pct) phase_next = PH_PCT;
            end
        endcase

        if (s_last) phase_next = PH_IDLE;
    end

    assign push = s_fire && (push_job.cnt != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            digit_reg <= '0;
        end else if (s_fire) begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
        end
    end

    `ASSERT_RST(a_last_clears_escape, aclk, aresetn, s_fire && s_last |=> phase_reg == PH_IDLE, "escape pending after last beat")
    `ASSERT_RST(a_last_always_emits, aclk, aresetn, s_fire && s_last |-> push, "last beat produced no output")

endmodule
`default_nettype wire

@@ design/pdsel_queue.sv @@
// Short job queue between the front end and the output sequencer.
`default_nettype none
`include "assert_macros.svh"
module pdsel_queue #(
    parameter int DEPTH = pdsel_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     push,
    input  pdsel_pkg::pdsel_job_t   push_job,
    output logic                    full,
    input  wire                     pop,
    output pdsel_pkg::pdsel_job_t   head,
    output logic                    empty
);
    import pdsel_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pdsel_job_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_job;
    end

    `ASSERT_RST(a_no_overflow, aclk, aresetn, push |-> !full, "push into full queue")
    `ASSERT_RST(a_no_underflow, aclk, aresetn, pop |-> !empty, "pop from empty queue")

endmodule
`default_nettype wire

@@ design/pdsel_back.sv @@
// Back end: walks the head run of the queue and emits one byte per beat.
`default_nettype none
`include "assert_macros.svh"
module pdsel_back (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  pdsel_pkg::pdsel_job_t   head,
    input  wire                     empty,
    output logic                    pop,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [7:0]              m_byte,
    output logic                    m_run_end,
    output logic                    m_msg_end
);
    import pdsel_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       m_fire;

    assign m_valid   = !empty;
    assign m_byte    = head.data[idx_reg];
    assign m_run_end = (idx_reg == head.cnt - 2'd1);
    assign m_msg_end = m_run_end && head.last;
    assign m_fire    = m_valid && m_ready;
    assign pop       = m_fire && m_run_end;

    always_comb begin
        idx_next = idx_reg;
        if (m_fire) idx_next = m_run_end ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    `ASSERT_RST(a_idx_in_run, aclk, aresetn, m_valid |-> idx_reg < head.cnt, "byte index past end of run")

endmodule
`default_nettype wire

@@ tb/tb_percent_decoder_selective.sv @@
// Self-checking testbench for the selective percent decoder: directed and random messages.
module tb_percent_decoder_selective;
    import pdsel_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 136;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIG} esc_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       msg_end;
    } dec_out_t;

    class decode_board;
        esc_phase_t phase;
        logic [7:0] held_digit;
        logic [7:0] run_q[$];
        dec_out_t   pending_q[$];
        int         errors;

        function new();
            phase      = ESC_NONE;
            held_digit = '0;
            errors     = 0;
        endfunction

        function logic hex_nibble(input logic [7:0] c, output logic [3:0] val);
            val = '0;
            if (c >= "0" && c <= "9") begin
                val = 4'(c - "0");
                return 1'b1;
            end
            if (c >= "A" && c <= "F") begin
                val = 4'(c - "A" + 10);
                return 1'b1;
            end
            if (c >= "a" && c <= "f") begin
                val = 4'(c - "a" + 10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Bytes whose escape is kept as-is instead of decoded.
        function logic passes_raw(input logic [7:0] v);
            logic [7:0] lc;
            lc = v | 8'h20;
            case (v)
                "!", "$", ":", ";", "=", "?", "@", "_": return 1'b1;
                default: return (v >= "0" && v <= "9") || (lc >= "a" && lc <= "z") ||
                                (v >= "&" && v <= "/");
            endcase
        endfunction

        function void decode_plain(input logic [7:0] b, input logic l);
            if (b == CH_PLUS) begin
                run_q.push_back(CH_SPACE);
            end else if (b == CH_PCT) begin
                if (l) run_q.push_back(CH_PCT);
                else phase = ESC_PCT;
            end else begin
                run_q.push_back(b);
            end
        endfunction

        function void predict_beat(input logic [7:0] b, input logic l);
            esc_phase_t ph;
            logic [3:0] lo, hi;
            logic       lo_ok, hi_ok;
            logic [7:0] v;
            dec_out_t   r;
            run_q.delete();
            ph    = phase;
            phase = ESC_NONE;
            lo_ok = hex_nibble(b, lo);
            case (ph)
                ESC_PCT: begin
                    if (lo_ok) begin
                        if (l) begin
                            run_q.push_back(CH_PCT);
                            run_q.push_back(b);
                        end else begin
                            held_digit = b;
                            phase      = ESC_DIG;
                        end
                    end else begin
                        run_q.push_back(CH_PCT);
                        decode_plain(b, l);
                    end
                end
                ESC_DIG: begin
                    hi_ok = hex_nibble(held_digit, hi);
                    if (lo_ok && hi_ok) begin
                        v = {hi, lo};
                        if (passes_raw(v)) begin
                            run_q.push_back(CH_PCT);
                            run_q.push_back(held_digit);
                            run_q.push_back(b);
                        end else begin
                            run_q.push_back(v);
                        end
                    end else begin
                        run_q.push_back(CH_PCT);
                        run_q.push_back(held_digit);
                        decode_plain(b, l);
                    end
                end
                default: decode_plain(b, l);
            endcase
            if (l) phase = ESC_NONE;
            foreach (run_q[i]) begin
                r.data    = run_q[i];
                r.run_end = (i == run_q.size() - 1);
                r.msg_end = r.run_end && l;
                pending_q.push_back(r);
            end
        endfunction

        function void check_byte(input logic [7:0] d, input logic re, input logic me);
            dec_out_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected output beat byte=%02h run_end=%0b msg_end=%0b",
                         $time, d, re, me);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (d !== e.data) begin
                $display("%0t: m_byte expected %02h actual %02h", $time, e.data, d);
                errors++;
            end
            if (re !== e.run_end) begin
                $display("%0t: m_run_end expected %0b actual %0b", $time, e.run_end, re);
                errors++;
            end
            if (me !== e.msg_end) begin
                $display("%0t: m_msg_end expected %0b actual %0b", $time, e.msg_end, me);
                errors++;
            end
        endfunction
    endclass

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte  = '0;
    logic       s_last  = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_byte;
    logic       m_run_end;
    logic       m_msg_end;

    decode_board board;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_sent     = 0;
    int          quiet_cycles   = 0;

    percent_decoder_selective u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte    (s_byte),
        .s_last    (s_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_byte    (m_byte),
        .m_run_end (m_run_end),
        .m_msg_end (m_msg_end)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Input beats are noted before output beats are checked on the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.predict_beat(s_byte, s_last);
            if (m_valid && m_ready) board.check_byte(m_byte, m_run_end, m_msg_end);
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("tb_percent_decoder_selective NOT OK");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte  <= b;
        s_last  <= l;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_msg(input logic [7:0] msg[$]);
        foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
    endtask

    // Drop valid and hold off until every predicted byte has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending_q.size() > 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_hex();
        int r;
        r = $urandom_range(21);
        if (r < 10) return 8'("0" + r);
        if (r < 16) return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] c;
        logic [3:0] dummy;
        do c = 8'($urandom_range(255)); while (board.hex_nibble(c, dummy));
        return c;
    endfunction

    task automatic build_random_msg(output logic [7:0] msg[$]);
        int n;
        int kind;
        bit noise;
        msg.delete();
        n     = $urandom_range(6, 1);
        noise = ($urandom_range(7) == 0);
        repeat (n) begin
            kind = noise ? 5 : $urandom_range(9);
            case (kind)
                0, 1, 2, 3: begin
                    msg.push_back(CH_PCT);
                    msg.push_back(pick_hex());
                    msg.push_back(pick_hex());
                end
                4: msg.push_back(CH_PLUS);
                5: msg.push_back(8'($urandom_range(255)));
                6: msg.push_back(8'("a" + $urandom_range(25)));
                7: msg.push_back(CH_PCT);
                8: begin
                    msg.push_back(CH_PCT);
                    msg.push_back(pick_hex());
                end
                default: begin
                    msg.push_back(CH_PCT);
                    if ($urandom_range(1)) msg.push_back(pick_hex());
                    msg.push_back(pick_non_hex());
                end
            endcase
        end
    endtask

    initial begin
        logic [7:0] msg[$];
        int         base;
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, plus, safe passthrough at end of message
        msg = {8'h00, 8'hFF};                  send_msg(msg);
        msg = {"+", "%", "4", "1"};            send_msg(msg);
        msg = {"%", "2", "0"};                 send_msg(msg);
        // broken escapes after '%' and after '%'+digit
        msg = {"%", "z", "%", "4", "z"};       send_msg(msg);
        // pending escape flushed by the last byte
        msg = {"%"};                           send_msg(msg);
        msg = {"%", "4"};                      send_msg(msg);
        // '%' restarting an escape, lowercase hex, zero byte escape
        msg = {"%", "%", "7", "e", "%", "0", "0"}; send_msg(msg);
        // high bytes are never hex digits
        msg = {8'h80, "%", "F", 8'hC1};        send_msg(msg);
        wait_drained();

        base = items_sent;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            while (items_sent < base + (p + 1) * RANDOM_ITEMS / 4) begin
                build_random_msg(msg);
                send_msg(msg);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("tb_percent_decoder_selective OK");
        end else begin
            $display("tb_percent_decoder_selective NOT OK");
        end
        $finish;
    end

endmodule
